// File: rtl/awsc_pkg.sv
// ----------------------------------------------------------------------------
// awsc_pkg
// Shared types and constants for the adaptive window sender controller.
// ----------------------------------------------------------------------------
package awsc_pkg;

    localparam int SEQ_W   = 34;
    localparam int CNT_W   = 32;
    localparam int RETRY_W = 8;
    localparam int DIV_W   = 8;
    localparam int KIND_W  = 3;
    localparam int FLAG_W  = 2;
    localparam int CIDX_W  = 2;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_HANDSHAKE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SEND      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ACK       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FINISH    = 3'd4;

    // header flags
    localparam logic [FLAG_W-1:0] FLAG_NONE    = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_FINISH  = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_ACK_REQ = 2'd2;

    // config register indexes
    localparam logic [CIDX_W-1:0] CFG_BACKOFF  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_RETRY    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_INIT_SEQ = 2'd2;

    // config reset values
    localparam logic [DIV_W-1:0]   BACKOFF_RST  = 8'd4;
    localparam logic [RETRY_W-1:0] RETRY_RST    = 8'd15;
    localparam logic [SEQ_W-1:0]   INIT_SEQ_RST = 34'd1000000000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  ack_sequence;
        logic              ack_flag;
    } cmd_word_t;

    typedef struct packed {
        logic              packet_valid;
        logic [FLAG_W-1:0] packet_flag;
        logic [SEQ_W-1:0]  packet_sequence;
        logic [CNT_W-1:0]  chunk_number;
        logic              await_ack;
        logic              link_status;
        logic [CNT_W-1:0]  good_total;
        logic [CNT_W-1:0]  bad_total;
    } rsp_word_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic commit;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic rsp_free;
    } dp_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_COMMIT
    } ctl_state_t;

endpackage

// File: rtl/awsc_div.sv
// ----------------------------------------------------------------------------
// awsc_div
// Restoring divider, one quotient bit per cycle. Divisor of zero acts as one.
// ----------------------------------------------------------------------------
module awsc_div #(
    parameter int WINDOW_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [WINDOW_BITS-1:0]             dividend,
    input  logic [awsc_pkg::DIV_W-1:0]         divisor,
    output logic [WINDOW_BITS-1:0]             quotient,
    output logic                               done
);
    import awsc_pkg::*;

    localparam int STEP_W = $clog2(WINDOW_BITS + 1);

    logic [WINDOW_BITS-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]       dvs_reg, dvs_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_W:0]         trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        trial     = {rem_reg, quo_reg[WINDOW_BITS-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = (divisor == '0) ? DIV_W'(1) : divisor;
            step_next = STEP_W'(WINDOW_BITS);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[WINDOW_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[WINDOW_BITS-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// File: rtl/awsc_datapath.sv
// ----------------------------------------------------------------------------
// awsc_datapath
// Session state, config registers, event update logic and result register.
// ----------------------------------------------------------------------------
module awsc_datapath #(
    parameter int WINDOW_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [awsc_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [awsc_pkg::SEQ_W-1:0]    cfg_data,
    input  awsc_pkg::cmd_word_t           cmd,
    input  logic                          rsp_stall,
    input  awsc_pkg::ctl_cmd_t            ctl,
    output awsc_pkg::dp_status_t          stat,
    output logic                          rsp_valid,
    output awsc_pkg::rsp_word_t           rsp
);
    import awsc_pkg::*;

    localparam int WB = WINDOW_BITS;

    // config
    logic [DIV_W-1:0]   backoff_reg;
    logic [RETRY_W-1:0] retry_lim_reg;
    logic [SEQ_W-1:0]   init_seq_reg;

    // session state
    logic [SEQ_W-1:0]   next_seq_reg, next_seq_next;
    logic [SEQ_W-1:0]   exp_ack_reg, exp_ack_next;
    logic [CNT_W-1:0]   chunk_reg, chunk_next;
    logic [WB-1:0]      win_lim_reg, win_lim_next;
    logic [WB-1:0]      win_fill_reg, win_fill_next;
    logic [RETRY_W-1:0] retry_reg, retry_next;
    logic [CNT_W-1:0]   good_reg, good_next;
    logic [CNT_W-1:0]   bad_reg, bad_next;
    logic               lost_reg, lost_next;

    cmd_word_t          cmd_reg;
    rsp_word_t          rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic [WB-1:0]      quotient;
    logic               div_done;

    // update terms
    logic               pending;
    logic [SEQ_W:0]     seq_inc, iseq_inc;
    logic [SEQ_W-1:0]   seq_inc_sat, iseq_inc_sat;
    logic [CNT_W:0]     chunk_inc;
    logic [WB:0]        fill_inc, lim_inc, quo_inc;
    logic [WB-1:0]      fill_inc_sat;
    logic [CNT_W:0]     lim_plus1, good_sum;
    logic [CNT_W-1:0]   lim_plus1_sat;
    logic [SEQ_W-1:0]   diff;
    logic [SEQ_W:0]     bad_sum, back;
    logic [RETRY_W:0]   retry_inc;
    logic [RETRY_W-1:0] retry_sat;

    awsc_div #(
        .WINDOW_BITS(WB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (win_lim_reg),
        .divisor  (backoff_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign pending = (win_fill_reg != '0) && (win_fill_reg == win_lim_reg);

    assign stat.need_div = (cmd_reg.kind == KIND_ACK) && !lost_reg && pending
                           && (cmd_reg.ack_sequence != exp_ack_reg);
    assign stat.div_done = div_done;
    assign stat.rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        seq_inc       = {1'b0, next_seq_reg} + (SEQ_W+1)'(1);
        seq_inc_sat   = seq_inc[SEQ_W] ? '1 : seq_inc[SEQ_W-1:0];
        iseq_inc      = {1'b0, init_seq_reg} + (SEQ_W+1)'(1);
        iseq_inc_sat  = iseq_inc[SEQ_W] ? '1 : iseq_inc[SEQ_W-1:0];
        chunk_inc     = {1'b0, chunk_reg} + (CNT_W+1)'(1);
        fill_inc      = {1'b0, win_fill_reg} + (WB+1)'(1);
        fill_inc_sat  = fill_inc[WB] ? '1 : fill_inc[WB-1:0];
        lim_inc       = {1'b0, win_lim_reg} + (WB+1)'(1);
        quo_inc       = {1'b0, quotient} + (WB+1)'(1);
        lim_plus1     = (CNT_W+1)'(win_lim_reg) + (CNT_W+1)'(1);
        lim_plus1_sat = lim_plus1[CNT_W] ? '1 : lim_plus1[CNT_W-1:0];
        good_sum      = {1'b0, good_reg} + {1'b0, lim_plus1_sat};
        diff          = (next_seq_reg > cmd_reg.ack_sequence)
                        ? next_seq_reg - cmd_reg.ack_sequence : '0;
        bad_sum       = (SEQ_W+1)'(bad_reg) + (SEQ_W+1)'(diff);
        back          = (SEQ_W+1)'(diff) + (SEQ_W+1)'(cmd_reg.ack_flag);
        retry_inc     = {1'b0, retry_reg} + (RETRY_W+1)'(1);
        retry_sat     = retry_inc[RETRY_W] ? '1 : retry_inc[RETRY_W-1:0];

        next_seq_next = next_seq_reg;
        exp_ack_next  = exp_ack_reg;
        chunk_next    = chunk_reg;
        win_lim_next  = win_lim_reg;
        win_fill_next = win_fill_reg;
        retry_next    = retry_reg;
        good_next     = good_reg;
        bad_next      = bad_reg;
        lost_next     = lost_reg;

        rsp_next                 = '0;
        rsp_next.packet_flag     = FLAG_NONE;

        if (cmd_reg.kind == KIND_HANDSHAKE)
        begin
            next_seq_next = iseq_inc_sat;
            exp_ack_next  = iseq_inc_sat;
            chunk_next    = '0;
            win_lim_next  = WB'(1);
            win_fill_next = '0;
            retry_next    = '0;
            good_next     = '0;
            bad_next      = '0;
            lost_next     = 1'b0;
            rsp_next.packet_valid    = 1'b1;
            rsp_next.packet_flag     = FLAG_ACK_REQ;
            rsp_next.packet_sequence = init_seq_reg;
            rsp_next.await_ack       = 1'b1;
        end
        else if (!lost_reg)
        begin
            case (cmd_reg.kind)
                KIND_SEND:
                begin
                    if (pending)
                    begin
                        rsp_next.await_ack = 1'b1;
                    end
                    else
                    begin
                        win_fill_next = fill_inc_sat;
                        exp_ack_next  = next_seq_reg;
                        next_seq_next = seq_inc_sat;
                        chunk_next    = chunk_inc[CNT_W] ? '1 : chunk_inc[CNT_W-1:0];
                        rsp_next.packet_valid    = 1'b1;
                        rsp_next.packet_sequence = next_seq_reg;
                        rsp_next.chunk_number    = chunk_reg;
                        if (fill_inc_sat == win_lim_reg)
                        begin
                            rsp_next.packet_flag = FLAG_ACK_REQ;
                            rsp_next.await_ack   = 1'b1;
                        end
                    end
                end
                KIND_ACK:
                begin
                    if (pending)
                    begin
                        win_fill_next = '0;
                        if (cmd_reg.ack_sequence == exp_ack_reg)
                        begin
                            good_next    = good_sum[CNT_W] ? '1 : good_sum[CNT_W-1:0];
                            win_lim_next = lim_inc[WB] ? '1 : lim_inc[WB-1:0];
                            retry_next   = '0;
                        end
                        else
                        begin
                            // backoff: quotient from the divider, rewind to receiver
                            win_lim_next  = quo_inc[WB] ? '1 : quo_inc[WB-1:0];
                            bad_next      = (bad_sum[SEQ_W:CNT_W] != '0)
                                            ? '1 : bad_sum[CNT_W-1:0];
                            chunk_next    = ((SEQ_W+1)'(chunk_reg) > back)
                                            ? chunk_reg - back[CNT_W-1:0] : '0;
                            next_seq_next = cmd_reg.ack_sequence;
                        end
                    end
                end
                KIND_TIMEOUT:
                begin
                    retry_next = retry_sat;
                    if (pending)
                    begin
                        win_fill_next = win_fill_reg - WB'(1);
                    end
                    if (retry_sat >= retry_lim_reg)
                    begin
                        lost_next = 1'b1;
                    end
                end
                KIND_FINISH:
                begin
                    rsp_next.packet_valid    = 1'b1;
                    rsp_next.packet_flag     = FLAG_FINISH;
                    rsp_next.packet_sequence = next_seq_reg;
                    rsp_next.await_ack       = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        rsp_next.link_status = lost_next;
        rsp_next.good_total  = good_next;
        rsp_next.bad_total   = bad_next;

        rsp_valid_next = ctl.commit ? 1'b1 : (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backoff_reg   <= BACKOFF_RST;
            retry_lim_reg <= RETRY_RST;
            init_seq_reg  <= INIT_SEQ_RST;
            next_seq_reg  <= INIT_SEQ_RST;
            exp_ack_reg   <= '0;
            chunk_reg     <= '0;
            win_lim_reg   <= WB'(1);
            win_fill_reg  <= '0;
            retry_reg     <= '0;
            good_reg      <= '0;
            bad_reg       <= '0;
            lost_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_BACKOFF:  backoff_reg   <= cfg_data[DIV_W-1:0];
                    CFG_RETRY:    retry_lim_reg <= cfg_data[RETRY_W-1:0];
                    CFG_INIT_SEQ: init_seq_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (ctl.commit)
            begin
                next_seq_reg <= next_seq_next;
                exp_ack_reg  <= exp_ack_next;
                chunk_reg    <= chunk_next;
                win_lim_reg  <= win_lim_next;
                win_fill_reg <= win_fill_next;
                retry_reg    <= retry_next;
                good_reg     <= good_next;
                bad_reg      <= bad_next;
                lost_reg     <= lost_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
        end
        if (ctl.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: rtl/awsc_ctrl.sv
// ----------------------------------------------------------------------------
// awsc_ctrl
// Sequencer: capture word, evaluate, optional backoff divide, commit.
// ----------------------------------------------------------------------------
module awsc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  awsc_pkg::dp_status_t  stat,
    output awsc_pkg::ctl_cmd_t    ctl
);
    import awsc_pkg::*;

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        cmd_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.need_div)
                begin
                    ctl.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (stat.rsp_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/adaptive_window_sender_control_unit.sv
// Sequence: an accepted word is captured, evaluated and committed to the result
//   register; a wrong ack inserts the bit-serial window backoff divide before
//   the commit. A word is taken only once the previous one is committed, and
//   the commit waits while a stalled result still holds the output register.
// The next word is taken while a result still waits in the output register.
// Reset (rst_n, async low): config to defaults, session state reset, no result.
// ----------------------------------------------------------------------------
// adaptive_window_sender_control_unit
// Sender window controller: sequence numbers, chunk indexes, window growth
// on good acks, divide-down and rewind on bad acks, retry-limited timeouts.
// ----------------------------------------------------------------------------
module adaptive_window_sender_control_unit #(
    parameter int WINDOW_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // event channel
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  awsc_pkg::cmd_word_t           cmd,
    // result channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output awsc_pkg::rsp_word_t           rsp,
    // config write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [awsc_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [awsc_pkg::SEQ_W-1:0]    cfg_data
);
    import awsc_pkg::*;

    ctl_cmd_t   ctl;
    dp_status_t stat;

    // user must write config only while idle (unchecked); port never pushes back
    assign cfg_ready = 1'b1;

    // controller: capture, evaluate, optional divide, commit for each word
    awsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    // datapath: session state, update terms, divider, output register
    awsc_datapath #(
        .WINDOW_BITS(WINDOW_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .rsp_stall (rsp_stall),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    // one word in flight: after taking a word the event side stalls
    a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("event word taken while another is in flight");

    // a result never overwrites one still waiting downstream
    a_commit_free : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> (!rsp_valid || !rsp_stall))
        else $error("result committed over a stalled result");

    // divider needs several steps; done cannot follow start immediately
    a_div_latency : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_start |=> !stat.div_done)
        else $error("divider done one cycle after start");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the adaptive window sender controller. A scripted
// opening run is followed by config phases of randomized window sessions.
// Every result word is compared field by field with a typed result or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;
    import awsc_pkg::*;

    typedef longint unsigned u64_t;

    localparam int                WIN_BITS    = 16;
    localparam u64_t              WIN_MAX     = (u64_t'(1) << WIN_BITS) - 1;
    localparam u64_t              U32_MAX     = 64'hFFFF_FFFF;
    localparam u64_t              SEQ_MAX     = (u64_t'(1) << SEQ_W) - 1;
    localparam u64_t              RETRY_MAX   = 64'hFF;
    localparam logic [SEQ_W-1:0]  SEQ_TOP     = '1;
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam int                PHASE_WORDS = 225;
    localparam int                DRAIN_LIMIT = 20000;

    typedef struct {
        cmd_word_t w;
        bit        typed;   // row carries a hand-written result
        rsp_word_t want;
    } script_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    cmd_word_t           cmd       = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    rsp_word_t           rsp;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index = '0;
    logic [SEQ_W-1:0]    cfg_data  = '0;

    // no idling on either side while set
    bit                  calm = 1'b0;
    int                  fail_count = 0;

    // result words owed by the block, oldest first
    rsp_word_t           due_words[$];
    script_row_t         script[$];

    // predictor copy of the config registers
    logic [DIV_W-1:0]    set_divisor;
    logic [RETRY_W-1:0]  set_retry_limit;
    logic [SEQ_W-1:0]    set_init_seq;

    // predictor copy of the session state
    logic [SEQ_W-1:0]    win_next;
    logic [SEQ_W-1:0]    win_exp_ack;
    logic [CNT_W-1:0]    win_chunk;
    logic [WIN_BITS-1:0] win_limit;
    logic [WIN_BITS-1:0] win_fill;
    logic [RETRY_W-1:0]  win_retries;
    logic [CNT_W-1:0]    win_good;
    logic [CNT_W-1:0]    win_bad;
    logic                win_lost;

    adaptive_window_sender_control_unit #(
        .WINDOW_BITS (WIN_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Window predictor
    // ------------------------------------------------------------------------
    function automatic u64_t clip(input u64_t v, input u64_t cap);
        return (v > cap) ? cap : v;
    endfunction

    function automatic void clear_session();
        win_exp_ack = '0;
        win_chunk   = '0;
        win_limit   = WIN_BITS'(1);
        win_fill    = '0;
        win_retries = '0;
        win_good    = '0;
        win_bad     = '0;
        win_lost    = 1'b0;
    endfunction

    function automatic bit ack_due();
        return win_fill != '0 && win_fill == win_limit;
    endfunction

    // Advance the session by one event word and return the result word it owes.
    function automatic rsp_word_t step_window(input cmd_word_t w);
        rsp_word_t r;
        u64_t      divisor;
        u64_t      seq_gap;
        u64_t      rewind;
        r = '0;
        if (w.kind == KIND_HANDSHAKE)
        begin
            // restart: everything cleared, sequence restarts past the handshake
            clear_session();
            r.packet_valid    = 1'b1;
            r.packet_flag     = FLAG_ACK_REQ;
            r.packet_sequence = set_init_seq;
            r.await_ack       = 1'b1;
            win_next          = SEQ_W'(clip(u64_t'(set_init_seq) + 64'd1, SEQ_MAX));
            win_exp_ack       = win_next;
        end
        else if (win_lost || w.kind > KIND_FINISH)
        begin
            // dead link or spare kind: nothing happens
        end
        else if (w.kind == KIND_SEND)
        begin
            if (ack_due())
            begin
                r.await_ack = 1'b1;
            end
            else
            begin
                win_fill          = WIN_BITS'(clip(u64_t'(win_fill) + 64'd1, WIN_MAX));
                r.packet_valid    = 1'b1;
                r.packet_flag     = (win_fill == win_limit) ? FLAG_ACK_REQ : FLAG_NONE;
                r.packet_sequence = win_next;
                r.chunk_number    = win_chunk;
                r.await_ack       = (win_fill == win_limit);
                win_exp_ack       = win_next;
                win_next          = SEQ_W'(clip(u64_t'(win_next) + 64'd1, SEQ_MAX));
                win_chunk         = CNT_W'(clip(u64_t'(win_chunk) + 64'd1, U32_MAX));
            end
        end
        else if (w.kind == KIND_ACK)
        begin
            if (ack_due())
            begin
                if (w.ack_sequence == win_exp_ack)
                begin
                    // good ack: credit limit+1, grow window additively
                    win_good    = CNT_W'(clip(u64_t'(win_good)
                                              + clip(u64_t'(win_limit) + 64'd1, U32_MAX),
                                              U32_MAX));
                    win_limit   = WIN_BITS'(clip(u64_t'(win_limit) + 64'd1, WIN_MAX));
                    win_fill    = '0;
                    win_retries = '0;
                end
                else
                begin
                    // bad ack: divide window, rewind to the reported sequence
                    divisor   = (set_divisor == '0) ? 64'd1 : u64_t'(set_divisor);
                    seq_gap   = (win_next > w.ack_sequence) ?
                                u64_t'(win_next) - u64_t'(w.ack_sequence) : 64'd0;
                    rewind    = seq_gap + u64_t'(w.ack_flag);
                    win_limit = WIN_BITS'(clip(u64_t'(win_limit) / divisor + 64'd1, WIN_MAX));
                    win_fill  = '0;
                    win_bad   = CNT_W'(clip(u64_t'(win_bad) + seq_gap, U32_MAX));
                    win_chunk = CNT_W'((u64_t'(win_chunk) > rewind) ?
                                       u64_t'(win_chunk) - rewind : 64'd0);
                    win_next  = w.ack_sequence;
                end
            end
        end
        else if (w.kind == KIND_TIMEOUT)
        begin
            win_retries = RETRY_W'(clip(u64_t'(win_retries) + 64'd1, RETRY_MAX));
            if (ack_due())
                win_fill = win_fill - WIN_BITS'(1);
            if (win_retries >= set_retry_limit)
                win_lost = 1'b1;
        end
        else
        begin
            r.packet_valid    = 1'b1;
            r.packet_flag     = FLAG_FINISH;
            r.packet_sequence = win_next;
            r.await_ack       = 1'b1;
        end
        r.link_status = win_lost;
        r.good_total  = win_good;
        r.bad_total   = win_bad;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic rsp_word_t pkt(input bit v, input logic [FLAG_W-1:0] f,
                                      input logic [SEQ_W-1:0] s, input logic [CNT_W-1:0] c,
                                      input bit a, input bit l,
                                      input logic [CNT_W-1:0] g, input logic [CNT_W-1:0] b);
        rsp_word_t r;
        r.packet_valid    = v;
        r.packet_flag     = f;
        r.packet_sequence = s;
        r.chunk_number    = c;
        r.await_ack       = a;
        r.link_status     = l;
        r.good_total      = g;
        r.bad_total       = b;
        return r;
    endfunction

    function automatic void add_row(input logic [KIND_W-1:0] k, input logic [SEQ_W-1:0] s,
                                    input bit f, input bit typed, input rsp_word_t want);
        script_row_t row;
        row.w.kind         = k;
        row.w.ack_sequence = s;
        row.w.ack_flag     = f;
        row.typed          = typed;
        row.want           = want;
        script.push_back(row);
    endfunction

    // Random event shaped by the session: mostly legal traffic, some noise.
    function automatic cmd_word_t pick_event();
        cmd_word_t w;
        int        roll;
        int        back;
        w.kind         = KIND_SEND;
        w.ack_sequence = SEQ_W'({$urandom, $urandom});
        w.ack_flag     = 1'($urandom_range(0, 1));
        roll           = int'($urandom_range(0, 99));
        if (win_lost)
        begin
            if (roll < 60)
                w.kind = KIND_HANDSHAKE;
            else
                w.kind = KIND_W'($urandom_range(KIND_SEND, KIND_SPARE_HI));
        end
        else if (ack_due())
        begin
            if (roll < 55)
            begin
                w.kind         = KIND_ACK;
                w.ack_sequence = win_exp_ack;
            end
            else if (roll < 75)
            begin
                // wrong ack, mostly a little behind the head
                w.kind = KIND_ACK;
                back   = int'($urandom_range(0, int'(win_limit) + 2));
                if (roll < 70)
                    w.ack_sequence = (win_next > SEQ_W'(back)) ?
                                     win_next - SEQ_W'(back) : '0;
                else if (roll < 73)
                    w.ack_sequence = win_next + SEQ_W'(back);
            end
            else if (roll < 87)
            begin
                w.kind = KIND_TIMEOUT;
            end
            else if (roll < 93)
            begin
                w.kind = KIND_SEND;
            end
            else if (roll < 96)
            begin
                w.kind = KIND_FINISH;
            end
            else if (roll < 98)
            begin
                w.kind = KIND_HANDSHAKE;
            end
            else
            begin
                w.kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            end
        end
        else
        begin
            if (roll < 72)
                w.kind = KIND_SEND;
            else if (roll < 80)
                w.kind = KIND_ACK;
            else if (roll < 88)
                w.kind = KIND_TIMEOUT;
            else if (roll < 93)
                w.kind = KIND_FINISH;
            else if (roll < 96)
                w.kind = KIND_HANDSHAKE;
            else
                w.kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        end
        return w;
    endfunction

    // Offer one event word; on acceptance queue what it owes. Valid is only
    // dropped when a gap is taken, so it never toggles within one step.
    task automatic push_cmd(input cmd_word_t w, input bit typed, input rsp_word_t want);
        rsp_word_t predicted;
        int        pause;
        if (!calm && $urandom_range(0, 99) < 33)
        begin
            pause = int'(($urandom_range(0, 9) == 0) ? $urandom_range(7, 30)
                                                      : $urandom_range(1, 6));
            cmd_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= w;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        predicted = step_window(w);
        due_words.push_back(typed ? want : predicted);
    endtask

    // Caller drops cfg_valid after the last register of a batch.
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [SEQ_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_BACKOFF:  set_divisor     = data[DIV_W-1:0];
            CFG_RETRY:    set_retry_limit = data[RETRY_W-1:0];
            CFG_INIT_SEQ: set_init_seq    = data;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall, compare against the oldest owed word
    // ------------------------------------------------------------------------
    always @(posedge clk)
        rsp_stall <= !calm && ($urandom_range(0, 99) < 33);

    function automatic void check_field(input string fname, input u64_t want, input u64_t got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (due_words.size() == 0)
            begin
                $error("result word with nothing owed: %h", rsp);
                fail_count++;
            end
            else
            begin
                want = due_words.pop_front();
                check_field("packet_valid",    u64_t'(want.packet_valid),
                            u64_t'(rsp.packet_valid));
                check_field("packet_flag",     u64_t'(want.packet_flag),
                            u64_t'(rsp.packet_flag));
                check_field("packet_sequence", u64_t'(want.packet_sequence),
                            u64_t'(rsp.packet_sequence));
                check_field("chunk_number",    u64_t'(want.chunk_number),
                            u64_t'(rsp.chunk_number));
                check_field("await_ack",       u64_t'(want.await_ack),
                            u64_t'(rsp.await_ack));
                check_field("link_status",     u64_t'(want.link_status),
                            u64_t'(rsp.link_status));
                check_field("good_total",      u64_t'(want.good_total),
                            u64_t'(rsp.good_total));
                check_field("bad_total",       u64_t'(want.bad_total),
                            u64_t'(rsp.bad_total));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [DIV_W-1:0]   div_pick;
        logic [RETRY_W-1:0] retry_pick;
        logic [SEQ_W-1:0]   seq_pick;
        cmd_word_t          w;
        int                 n;
        int                 guard;

        set_divisor     = BACKOFF_RST;
        set_retry_limit = RETRY_RST;
        set_init_seq    = INIT_SEQ_RST;
        win_next        = INIT_SEQ_RST;
        clear_session();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scripted run on reset config. Rows with a typed result are ones
        // whose answer is obvious; the rest go through the predictor.
        // send before any handshake: one-slot window, ack requested at once
        add_row(KIND_SEND,      '0,                         1'b0, 1'b1,
                pkt(1'b1, FLAG_ACK_REQ, INIT_SEQ_RST, '0, 1'b1, 1'b0, '0, '0));
        // handshake ignores its ack fields and clears the session
        add_row(KIND_HANDSHAKE, SEQ_TOP,                    1'b1, 1'b1,
                pkt(1'b1, FLAG_ACK_REQ, INIT_SEQ_RST, '0, 1'b1, 1'b0, '0, '0));
        add_row(KIND_SEND,      '0,                         1'b0, 1'b0, '0);
        // send while the ack is outstanding: nothing sent, keep waiting
        add_row(KIND_SEND,      '0,                         1'b1, 1'b1,
                pkt(1'b0, FLAG_NONE, '0, '0, 1'b1, 1'b0, '0, '0));
        add_row(KIND_ACK,       INIT_SEQ_RST + SEQ_W'(1),   1'b1, 1'b0, '0); // good ack, window 2
        add_row(KIND_ACK,       INIT_SEQ_RST + SEQ_W'(1),   1'b0, 1'b0, '0); // nothing pending
        add_row(KIND_SEND,      '0,                         1'b0, 1'b0, '0);
        add_row(KIND_SEND,      '0,                         1'b0, 1'b0, '0);
        add_row(KIND_TIMEOUT,   '0,                         1'b0, 1'b0, '0); // frees one slot
        add_row(KIND_SEND,      '0,                         1'b0, 1'b0, '0);
        add_row(KIND_ACK,       INIT_SEQ_RST + SEQ_W'(2),   1'b1, 1'b0, '0); // bad ack, extra rewind
        add_row(KIND_SEND,      '0,                         1'b0, 1'b0, '0);
        add_row(KIND_ACK,       SEQ_TOP,                    1'b0, 1'b0, '0); // ack ahead of head
        add_row(KIND_SEND,      '0,                         1'b0, 1'b0, '0); // sequence pinned at top
        add_row(KIND_ACK,       '0,                         1'b1, 1'b0, '0); // huge gap, tallies pin
        add_row(KIND_FINISH,    SEQ_TOP,                    1'b1, 1'b0, '0);
        add_row(KIND_SPARE_LO,  SEQ_TOP,                    1'b1, 1'b0, '0);
        add_row(KIND_SPARE_HI,  '0,                         1'b0, 1'b0, '0);
        add_row(KIND_SEND,      '0,                         1'b0, 1'b0, '0);
        add_row(KIND_ACK,       '0,                         1'b0, 1'b0, '0); // good ack at seq zero
        add_row(KIND_TIMEOUT,   '0,                         1'b0, 1'b0, '0); // nothing pending
        add_row(KIND_HANDSHAKE, '0,                         1'b0, 1'b1,
                pkt(1'b1, FLAG_ACK_REQ, INIT_SEQ_RST, '0, 1'b1, 1'b0, '0, '0));

        foreach (script[i])
            push_cmd(script[i].w, script[i].typed, script[i].want);

        // Config phases: extremes first, then a calm default-like phase,
        // then random settings. Registers only change with nothing in flight.
        for (int ph = 0; ph < 8; ph++)
        begin
            cmd_valid <= 1'b0;
            while (due_words.size() != 0) @(posedge clk);

            case (ph)
                0:
                begin
                    div_pick   = DIV_W'(1);
                    retry_pick = RETRY_W'(1);
                    seq_pick   = '0;
                end
                1:
                begin
                    div_pick   = '1;
                    retry_pick = '1;
                    seq_pick   = SEQ_TOP;
                end
                2:
                begin
                    div_pick   = '0;
                    retry_pick = '0;
                    seq_pick   = 34'd9999999999;
                end
                3:
                begin
                    div_pick   = DIV_W'(2);
                    retry_pick = RETRY_RST;
                    seq_pick   = INIT_SEQ_RST;
                end
                default:
                begin
                    div_pick   = DIV_W'($urandom_range(0, 255));
                    retry_pick = ($urandom_range(0, 3) == 0) ? 8'd255
                                                             : RETRY_W'($urandom_range(1, 24));
                    seq_pick   = SEQ_W'({$urandom, $urandom});
                end
            endcase
            calm = (ph == 3);

            write_reg(CFG_BACKOFF,  SEQ_W'(div_pick));
            write_reg(CFG_RETRY,    SEQ_W'(retry_pick));
            write_reg(CFG_INIT_SEQ, seq_pick);
            cfg_valid <= 1'b0;

            // words that do nothing (spare kinds, anything but a handshake on a dead link) are not counted
            n = 0;
            while (n < PHASE_WORDS)
            begin
                w = pick_event();
                if (w.kind == KIND_HANDSHAKE || (!win_lost && w.kind <= KIND_FINISH))
                    n++;
                push_cmd(w, 1'b0, '0);
            end
        end

        cmd_valid <= 1'b0;
        calm = 1'b0;
        guard = 0;
        while (due_words.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (due_words.size() != 0)
        begin
            $error("%0d result words never arrived", due_words.size());
            fail_count++;
        end
        // room for a stray word, worst case a bad-ack divide
        repeat (WIN_BITS + 8) @(posedge clk);

        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial
    begin
        #5000000;
        $display("tb: errors");
        $finish;
    end

endmodule
